### sv/rpa_pkg.sv
// Shared types, register codes and fixed-point helpers for the rotation core.
// Depends on nothing; the core, rpa_cfg_regs, rpa_rot_pipe and both test files import it.
package rpa_pkg;

  // 1 rotates z as well; 0 passes z through unchanged on selected atoms.
  localparam logic RPA_THREE_D = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIVOT_X     = 3'd0,
    REG_PIVOT_Y     = 3'd1,
    REG_PIVOT_Z     = 3'd2,
    REG_AXIS_X      = 3'd3,
    REG_AXIS_Y      = 3'd4,
    REG_AXIS_Z      = 3'd5,
    REG_SINE_COSINE = 3'd6,
    REG_GROUP_SEL   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][31:0] pivot;      // Q16.16, index 0 = x
    logic [2:0][31:0] axis;       // Q2.30 unit axis
    logic [31:0]      sine;       // Q2.30
    logic [31:0]      cosine;     // Q2.30
    logic [31:0]      group_sel;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] atom_groups;
    logic        last_atom;
  } in_item_t;

  typedef struct packed {
    logic [31:0] new_x;
    logic [31:0] new_y;
    logic [31:0] new_z;
    logic        was_rotated;
    logic        last_out;
  } out_item_t;

  localparam logic signed [37:0] MID_HI = 38'sd4294967295;
  localparam logic signed [37:0] MID_LO = -38'sd4294967295;
  localparam logic signed [37:0] S32_HI = 38'sd2147483647;
  localparam logic signed [37:0] S32_LO = -38'sd2147483648;

  // Q16.16 times Q2.30, truncated toward minus infinity back to Q16.16.
  function automatic logic signed [34:0] mulq(input logic signed [32:0] a,
                                              input logic signed [31:0] r);
    logic signed [64:0] p;
    p = 65'(a) * 65'(r);
    return p[64:30];
  endfunction

  // Symmetric clamp to +-(2^32 - 1).
  function automatic logic signed [32:0] sat_mid(input logic signed [37:0] x);
    logic signed [37:0] y;
    if (x > MID_HI) begin
      y = MID_HI;
    end else if (x < MID_LO) begin
      y = MID_LO;
    end else begin
      y = x;
    end
    return y[32:0];
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
    logic signed [37:0] y;
    if (x > S32_HI) begin
      y = S32_HI;
    end else if (x < S32_LO) begin
      y = S32_LO;
    end else begin
      y = x;
    end
    return y[31:0];
  endfunction

endpackage

### sv/rpa_in_if.sv
// Input channel of the rotation core: one atom per request.
// Depends on nothing.
interface rpa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] atom_groups;
  logic        last_atom;

  modport source (output valid, pos_x, pos_y, pos_z, atom_groups, last_atom,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, atom_groups, last_atom,
                output ready);
endinterface

### sv/rpa_out_if.sv
// Result channel of the rotation core: one moved atom per request.
// Depends on nothing.
interface rpa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_x;
  logic [31:0] new_y;
  logic [31:0] new_z;
  logic        was_rotated;
  logic        last_out;

  modport source (output valid, new_x, new_y, new_z, was_rotated, last_out,
                  input ready);
  modport sink (input valid, new_x, new_y, new_z, was_rotated, last_out,
                output ready);
endinterface

### sv/rpa_cfg_if.sv
// Configuration write channel of the rotation core.
// Depends on nothing.
interface rpa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/rotate_point_about_axis_core.sv
// Top level of the rotation core: channels, register bank and datapath.
// Depends on rpa_pkg, the three channel interfaces, rpa_cfg_regs and rpa_rot_pipe.
//
//   Channel  Direction  Request carries
//   in_ch    sink       pos_x, pos_y, pos_z, atom_groups, last_atom
//   out_ch   source     new_x, new_y, new_z, was_rotated, last_out
//   cfg_ch   sink       index (register 0..7), data (64 bits)
//
// One atom request is accepted every cycle while results are taken; each result
// passes through the nine register stages of the multiplier chain.
// All stages share one advance enable, so when a finished result is not taken
// the whole pipeline holds and in_ch.ready drops; nothing is lost or repeated.
// rst_n is synchronous and active low; it empties the pipeline and restores
// the register defaults. Configuration writes are always ready.
module rotate_point_about_axis_core
  import rpa_pkg::*;
#(
  // 1 rotates z as well; 0 passes z through unchanged on selected atoms.
  parameter logic THREE_D = RPA_THREE_D
) (
  input  logic clk,
  input  logic rst_n,
  rpa_in_if.sink    in_ch,
  rpa_out_if.source out_ch,
  rpa_cfg_if.sink   cfg_ch
);

  cfg_t      cfg;
  in_item_t  in_item;
  out_item_t out_item;

  // The register bank takes a write in any cycle; software must write only while
  // no atom is in flight, since the datapath reads the registers directly; the block does not enforce this.
  assign cfg_ch.ready = 1'b1;

  rpa_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  assign in_item.pos_x       = in_ch.pos_x;
  assign in_item.pos_y       = in_ch.pos_y;
  assign in_item.pos_z       = in_ch.pos_z;
  assign in_item.atom_groups = in_ch.atom_groups;
  assign in_item.last_atom   = in_ch.last_atom;

  // Offset, projection onto the axis, cross product, then cosine and sine.
  rpa_rot_pipe #(
    .THREE_D (THREE_D)
  ) u_rot_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.new_x       = out_item.new_x;
  assign out_ch.new_y       = out_item.new_y;
  assign out_ch.new_z       = out_item.new_z;
  assign out_ch.was_rotated = out_item.was_rotated;
  assign out_ch.last_out    = out_item.last_out;

endmodule

### sv/rpa_cfg_regs.sv
// Configuration register bank of the rotation core.
// Depends on rpa_pkg for register codes and the cfg_t bundle.
module rpa_cfg_regs
  import rpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pivot     <= '0;
      cfg_r.axis      <= {32'h4000_0000, 32'h0, 32'h0};
      cfg_r.sine      <= 32'h0;
      cfg_r.cosine    <= 32'h4000_0000;
      cfg_r.group_sel <= 32'h1;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_PIVOT_X:     cfg_r.pivot[0] <= wr_data[31:0];
        REG_PIVOT_Y:     cfg_r.pivot[1] <= wr_data[31:0];
        REG_PIVOT_Z:     cfg_r.pivot[2] <= wr_data[31:0];
        REG_AXIS_X:      cfg_r.axis[0]  <= wr_data[31:0];
        REG_AXIS_Y:      cfg_r.axis[1]  <= wr_data[31:0];
        REG_AXIS_Z:      cfg_r.axis[2]  <= wr_data[31:0];
        REG_SINE_COSINE: begin
          cfg_r.sine   <= wr_data[63:32];
          cfg_r.cosine <= wr_data[31:0];
        end
        REG_GROUP_SEL:   cfg_r.group_sel <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/rpa_rot_pipe.sv
// Nine-stage rotation datapath: offset, projection, cross product, trig terms.
// Depends on rpa_pkg for item types and the fixed-point helpers.
module rpa_rot_pipe
  import rpa_pkg::*;
#(
  parameter logic THREE_D = RPA_THREE_D
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // All stages advance together; a stall holds every stage in place.
  logic en;
  logic [9:1] v_r;

  assign en        = !v_r[9] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[9];

  // Side data that rides along the stages.
  logic [8:1] sel_r;
  logic [8:1] last_r;

  logic signed [31:0] pos_r [1:8][3];
  logic signed [32:0] d_r   [1:4][3];
  logic signed [34:0] pd2_r [3];
  logic signed [32:0] dot3_r;
  logic signed [34:0] pc4_r [3];
  logic signed [32:0] c_r   [5:8][3];
  logic signed [32:0] a_r   [5:7][3];
  logic signed [34:0] m6_r  [6];
  logic signed [32:0] b7_r  [3];
  logic signed [34:0] ac8_r [3];
  logic signed [34:0] bs8_r [3];
  out_item_t          out_r;

  logic signed [31:0] pos_in [3];
  logic signed [31:0] piv    [3];
  logic signed [31:0] ax     [3];
  logic signed [31:0] sine;
  logic signed [31:0] cosine;

  always_comb begin
    pos_in[0] = $signed(in_item.pos_x);
    pos_in[1] = $signed(in_item.pos_y);
    pos_in[2] = $signed(in_item.pos_z);
    for (int i = 0; i < 3; i++) begin
      piv[i] = $signed(cfg.pivot[i]);
      ax[i]  = $signed(cfg.axis[i]);
    end
    sine   = $signed(cfg.sine);
    cosine = $signed(cfg.cosine);
  end

  // Final stage: displacement and the saturated coordinate.
  logic signed [32:0] disp [3];
  logic signed [31:0] res  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      disp[i] = sat_mid(38'(ac8_r[i]) + 38'(bs8_r[i]));
      res[i]  = sel_r[8] ? sat32(38'(piv[i]) + 38'(c_r[8][i]) + 38'(disp[i]))
                         : pos_r[8][i];
    end
    if (!THREE_D) begin
      res[2] = pos_r[8][2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[8:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_r  <= {sel_r[7:1], |(in_item.atom_groups & cfg.group_sel)};
      last_r <= {last_r[7:1], in_item.last_atom};

      // Stage 1: offset from the pivot.
      for (int i = 0; i < 3; i++) begin
        pos_r[1][i] <= pos_in[i];
        d_r[1][i]   <= 33'(pos_in[i]) - 33'(piv[i]);
      end
      for (int s = 2; s <= 8; s++) begin
        pos_r[s] <= pos_r[s-1];
      end
      for (int s = 2; s <= 4; s++) begin
        d_r[s] <= d_r[s-1];
      end

      // Stage 2: projection products.
      for (int i = 0; i < 3; i++) begin
        pd2_r[i] <= mulq(d_r[1][i], ax[i]);
      end

      // Stage 3: dot product.
      dot3_r <= sat_mid(38'(pd2_r[0]) + 38'(pd2_r[1]) + 38'(pd2_r[2]));

      // Stage 4: scale the axis by the projection.
      for (int i = 0; i < 3; i++) begin
        pc4_r[i] <= mulq(dot3_r, ax[i]);
      end

      // Stage 5: axial part and the perpendicular remainder.
      for (int i = 0; i < 3; i++) begin
        c_r[5][i] <= sat_mid(38'(pc4_r[i]));
        a_r[5][i] <= sat_mid(38'(d_r[4][i]) - 38'(sat_mid(38'(pc4_r[i]))));
      end
      for (int s = 6; s <= 8; s++) begin
        c_r[s] <= c_r[s-1];
      end
      for (int s = 6; s <= 7; s++) begin
        a_r[s] <= a_r[s-1];
      end

      // Stage 6: cross product terms of axis x remainder.
      m6_r[0] <= mulq(a_r[5][2], ax[1]);
      m6_r[1] <= mulq(a_r[5][1], ax[2]);
      m6_r[2] <= mulq(a_r[5][0], ax[2]);
      m6_r[3] <= mulq(a_r[5][2], ax[0]);
      m6_r[4] <= mulq(a_r[5][1], ax[0]);
      m6_r[5] <= mulq(a_r[5][0], ax[1]);

      // Stage 7: cross product.
      for (int i = 0; i < 3; i++) begin
        b7_r[i] <= sat_mid(38'(m6_r[2*i]) - 38'(m6_r[2*i+1]));
      end

      // Stage 8: cosine and sine terms.
      for (int i = 0; i < 3; i++) begin
        ac8_r[i] <= mulq(a_r[7][i], cosine);
        bs8_r[i] <= mulq(b7_r[i], sine);
      end

      // Stage 9: result register.
      out_r.new_x       <= res[0];
      out_r.new_y       <= res[1];
      out_r.new_z       <= res[2];
      out_r.was_rotated <= sel_r[8];
      out_r.last_out    <= last_r[8];
    end
  end

  assign out_item = out_r;

endmodule

### test/rpa_move_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the rotation core: watches the atom, result and register channels,
// predicts every moved atom and compares it with what comes out.
// Depends on rpa_pkg and the three channel interfaces in sv/.
module rpa_move_checker
  import rpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rpa_in_if    in_ch,
  rpa_out_if   out_ch,
  rpa_cfg_if   cfg_ch,
  output int   open_cnt,
  output int   fail_cnt
);

  // Shadow copy of the register bank; pivot and axis are kept in wide signed form.
  longint      piv [3];
  longint      axs [3];
  logic [63:0] sin_cos;
  logic [31:0] grp_sel;

  out_item_t pending_moves[$];
  out_item_t want;
  in_item_t  got_atom;
  int        errs;
  int        move_no;

  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // Q16.16 times Q2.30; the arithmetic shift rounds toward minus infinity.
  function automatic longint fx_mul(input longint a, input longint r);
    return (a * r) >>> 30;
  endfunction

  function automatic longint clamp_wide(input longint v);
    if (v > 64'sd4294967295) return 64'sd4294967295;
    if (v < -64'sd4294967295) return -64'sd4294967295;
    return v;
  endfunction

  function automatic longint clamp_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Expected result of one atom under the current register settings.
  function automatic out_item_t rotate_atom(input in_item_t a);
    longint    p [3];
    longint    d [3];
    longint    c [3];
    longint    av [3];
    longint    b [3];
    longint    q [3];
    longint    dot;
    longint    sn;
    longint    cs;
    out_item_t r;
    p[0] = sx(a.pos_x);
    p[1] = sx(a.pos_y);
    p[2] = sx(a.pos_z);
    r.new_x = a.pos_x;
    r.new_y = a.pos_y;
    r.new_z = a.pos_z;
    r.was_rotated = |(a.atom_groups & grp_sel);
    r.last_out = a.last_atom;
    if (r.was_rotated) begin
      sn = sx(sin_cos[63:32]);
      cs = sx(sin_cos[31:0]);
      for (int i = 0; i < 3; i++) d[i] = p[i] - piv[i];
      dot = clamp_wide(fx_mul(d[0], axs[0]) + fx_mul(d[1], axs[1]) + fx_mul(d[2], axs[2]));
      for (int i = 0; i < 3; i++) begin
        c[i] = clamp_wide(fx_mul(dot, axs[i]));
        av[i] = clamp_wide(d[i] - c[i]);
      end
      b[0] = clamp_wide(fx_mul(av[2], axs[1]) - fx_mul(av[1], axs[2]));
      b[1] = clamp_wide(fx_mul(av[0], axs[2]) - fx_mul(av[2], axs[0]));
      b[2] = clamp_wide(fx_mul(av[1], axs[0]) - fx_mul(av[0], axs[1]));
      for (int i = 0; i < 3; i++) begin
        q[i] = clamp_word(piv[i] + c[i] + clamp_wide(fx_mul(av[i], cs) + fx_mul(b[i], sn)));
      end
      r.new_x = 32'(q[0]);
      r.new_y = 32'(q[1]);
      if (RPA_THREE_D) begin
        r.new_z = 32'(q[2]);
      end
    end
    return r;
  endfunction

  task automatic compare_field(input string label, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errs++;
      $display("%0t: result %0d %s mismatch, expected %h, got %h",
               $time, move_no, label, exp_v, got_v);
    end
  endtask

  initial begin
    errs = 0;
    move_no = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      piv[0] = 0;
      piv[1] = 0;
      piv[2] = 0;
      axs[0] = 0;
      axs[1] = 0;
      axs[2] = 64'sd1073741824;
      sin_cos = 64'h0000_0000_4000_0000;
      grp_sel = 32'h1;
      pending_moves.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (reg_idx_t'(cfg_ch.index))
          REG_PIVOT_X:     piv[0] = sx(cfg_ch.data[31:0]);
          REG_PIVOT_Y:     piv[1] = sx(cfg_ch.data[31:0]);
          REG_PIVOT_Z:     piv[2] = sx(cfg_ch.data[31:0]);
          REG_AXIS_X:      axs[0] = sx(cfg_ch.data[31:0]);
          REG_AXIS_Y:      axs[1] = sx(cfg_ch.data[31:0]);
          REG_AXIS_Z:      axs[2] = sx(cfg_ch.data[31:0]);
          REG_SINE_COSINE: sin_cos = cfg_ch.data;
          REG_GROUP_SEL:   grp_sel = cfg_ch.data[31:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        got_atom.pos_x = in_ch.pos_x;
        got_atom.pos_y = in_ch.pos_y;
        got_atom.pos_z = in_ch.pos_z;
        got_atom.atom_groups = in_ch.atom_groups;
        got_atom.last_atom = in_ch.last_atom;
        pending_moves.push_back(rotate_atom(got_atom));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_moves.size() == 0) begin
          errs++;
          $display("%0t: result %0d with no request pending, expected none,",
                   $time, move_no);
          $display("    got x=%h y=%h z=%h", out_ch.new_x, out_ch.new_y, out_ch.new_z);
        end else begin
          want = pending_moves.pop_front();
          compare_field("new_x", want.new_x, out_ch.new_x);
          compare_field("new_y", want.new_y, out_ch.new_y);
          compare_field("new_z", want.new_z, out_ch.new_z);
          compare_field("was_rotated", {31'b0, want.was_rotated}, {31'b0, out_ch.was_rotated});
          compare_field("last_out", {31'b0, want.last_out}, {31'b0, out_ch.last_out});
        end
        move_no++;
      end
    end
    open_cnt <= pending_moves.size();
    fail_cnt <= errs;
  end

endmodule

### test/rotate_point_about_axis_core_test.sv
`timescale 1ns / 100ps
// Top of the rotation core testbench: clock, reset, atom and register stimulus,
// result back-pressure and the verdict. Depends on rpa_pkg, the channel
// interfaces, rotate_point_about_axis_core and rpa_move_checker.
module rotate_point_about_axis_core_test
  import rpa_pkg::*;
;

  localparam int ATOMS_PER_PHASE = 100;
  localparam int RANDOM_PHASES   = 14;
  // The pipeline is nine stages deep; this covers it with margin when
  // waiting for stray results at a phase boundary and at the end.
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 1000000;

  logic clk;
  logic rst_n;

  rpa_in_if  in_ch ();
  rpa_out_if out_ch ();
  rpa_cfg_if cfg_ch ();

  int open_cnt;
  int fail_cnt;

  // Set by the stimulus to ask the result side for one long hold-off.
  bit sink_hold_req;
  // Percent chance that the atom sender idles before a request.
  int gap_pct;

  in_item_t corner_atoms [6];

  rotate_point_about_axis_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rpa_move_checker checker_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_ch   (cfg_ch),
    .open_cnt (open_cnt),
    .fail_cnt (fail_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the handshakes ever lock up.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side. Ready alternates between runs of acceptance and stalls. Most
  // stalls are short, some are long, and some runs are long enough to
  // give stall-free stretches. When the stimulus raises sink_hold_req the
  // receiver cuts its current run short and refuses results for HOLD_CYCLES,
  // which fills the pipeline and forces the core to drop in_ch.ready while
  // atoms keep being offered.
  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    forever begin
      if (sink_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold_req = 1'b0;
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
        out_ch.ready <= 1'b1;
        for (int k = 0; k < n && !sink_hold_req; k++) @(posedge clk);
        case ($urandom_range(0, 9))
          0, 1, 2: n = 0;
          3:       n = $urandom_range(10, 60);
          default: n = $urandom_range(1, 4);
        endcase
        if (n > 0 && !sink_hold_req) begin
          out_ch.ready <= 1'b0;
          for (int k = 0; k < n && !sink_hold_req; k++) @(posedge clk);
        end
      end
    end
  end

  // Writes all eight registers back to back. The 32-bit registers get random
  // upper data bits, which the core must ignore.
  task automatic load_settings(input cfg_t s);
    logic [63:0] word;
    reg_idx_t    idx;
    for (int k = 0; k < 8; k++) begin
      idx = reg_idx_t'(k);
      case (idx)
        REG_PIVOT_X, REG_PIVOT_Y, REG_PIVOT_Z: word = {$urandom, s.pivot[k]};
        REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z:    word = {$urandom, s.axis[k - 3]};
        REG_SINE_COSINE:                       word = {s.sine, s.cosine};
        default:                               word = {$urandom, s.group_sel};
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= word;
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Offers one atom, possibly after an idle gap, and returns once it is taken.
  // Valid stays high between back-to-back requests.
  task automatic offer_atom(input in_item_t a);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pos_x       <= a.pos_x;
    in_ch.pos_y       <= a.pos_y;
    in_ch.pos_z       <= a.pos_z;
    in_ch.atom_groups <= a.atom_groups;
    in_ch.last_atom   <= a.last_atom;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops sending and waits until every predicted result has been checked,
  // then a little longer so that no result is still in flight.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A proper rotation: random unit axis, random angle, pivot near the origin.
  function automatic cfg_t unit_setting();
    real  ux;
    real  uy;
    real  uz;
    real  len;
    real  ang;
    cfg_t s;
    do begin
      ux = $urandom_range(0, 2000) / 1000.0 - 1.0;
      uy = $urandom_range(0, 2000) / 1000.0 - 1.0;
      uz = $urandom_range(0, 2000) / 1000.0 - 1.0;
      len = $sqrt(ux * ux + uy * uy + uz * uz);
    end while (len < 0.1 || len > 1.0);
    ang = $urandom_range(0, 62831) / 10000.0;
    s.axis[0] = 32'($rtoi(ux / len * 1073741824.0));
    s.axis[1] = 32'($rtoi(uy / len * 1073741824.0));
    s.axis[2] = 32'($rtoi(uz / len * 1073741824.0));
    s.sine    = 32'($rtoi($sin(ang) * 1073741824.0));
    s.cosine  = 32'($rtoi($cos(ang) * 1073741824.0));
    for (int i = 0; i < 3; i++) begin
      s.pivot[i] = 32'($urandom_range(0, 1 << 27)) - 32'(1 << 26);
    end
    case ($urandom_range(0, 9))
      0:       s.group_sel = 32'h0;
      1:       s.group_sel = 32'hffff_ffff;
      2:       s.group_sel = $urandom;
      default: s.group_sel = 32'h1 << $urandom_range(0, 31);
    endcase
    return s;
  endfunction

  // Every field at a range end or at plus or minus one in Q2.30.
  function automatic cfg_t corner_setting();
    logic [31:0] ends [4];
    cfg_t        s;
    ends = '{32'h7fff_ffff, 32'h8000_0000, 32'h4000_0000, 32'hc000_0000};
    for (int i = 0; i < 3; i++) begin
      s.pivot[i] = ends[$urandom_range(0, 3)];
      s.axis[i]  = ends[$urandom_range(0, 3)];
    end
    s.sine      = ends[$urandom_range(0, 3)];
    s.cosine    = ends[$urandom_range(0, 3)];
    s.group_sel = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h8000_0000;
    return s;
  endfunction

  // Unnormalized axis and angle: only saturation bounds the result.
  function automatic cfg_t raw_setting();
    cfg_t s;
    for (int i = 0; i < 3; i++) begin
      s.pivot[i] = $urandom;
      s.axis[i]  = $urandom;
    end
    s.sine      = $urandom;
    s.cosine    = $urandom;
    s.group_sel = $urandom;
    return s;
  endfunction

  // Mostly points near the pivot, where the rotation is meaningful, plus full
  // random words and the range ends to exercise every bit and the clamps.
  function automatic logic [31:0] pick_coord(input logic [31:0] centre);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return centre + 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
    endcase
  endfunction

  function automatic in_item_t random_atom(input cfg_t s);
    in_item_t a;
    a.pos_x = pick_coord(s.pivot[0]);
    a.pos_y = pick_coord(s.pivot[1]);
    a.pos_z = pick_coord(s.pivot[2]);
    // Members of the selected group, strangers to it, and random masks.
    case ($urandom_range(0, 3))
      0:       a.atom_groups = $urandom;
      1:       a.atom_groups = s.group_sel;
      2:       a.atom_groups = 32'h1 << $urandom_range(0, 31);
      default: a.atom_groups = ~s.group_sel;
    endcase
    a.last_atom = ($urandom_range(0, 15) == 0);
    return a;
  endfunction

  initial begin : stimulus
    cfg_t s;

    // Corner atoms: range ends on all axes, unselected atoms under both a
    // narrow and a full group select, and the batch end mark.
    corner_atoms[0] = '{32'h0, 32'h0, 32'h0, 32'h1, 1'b0};
    corner_atoms[1] = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b1};
    corner_atoms[2] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1, 1'b0};
    corner_atoms[3] = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b0};
    corner_atoms[4] = '{32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, 32'hffff_fffe, 1'b1};
    corner_atoms[5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 1'b0};

    gap_pct = 0;
    sink_hold_req = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.pos_x       <= 32'h0;
    in_ch.pos_y       <= 32'h0;
    in_ch.pos_z       <= 32'h0;
    in_ch.atom_groups <= 32'h0;
    in_ch.last_atom   <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_PIVOT_X;
    cfg_ch.data  <= 64'h0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: identity rotation about z through the origin, group 0.
    foreach (corner_atoms[i]) offer_atom(corner_atoms[i]);
    drain();

    // Every register at a hostile extreme: saturation on all paths.
    s.pivot[0]  = 32'h7fff_ffff;
    s.pivot[1]  = 32'h8000_0000;
    s.pivot[2]  = 32'h7fff_ffff;
    s.axis[0]   = 32'h8000_0000;
    s.axis[1]   = 32'h7fff_ffff;
    s.axis[2]   = 32'hc000_0000;
    s.sine      = 32'h8000_0000;
    s.cosine    = 32'h7fff_ffff;
    s.group_sel = 32'hffff_ffff;
    load_settings(s);
    foreach (corner_atoms[i]) offer_atom(corner_atoms[i]);
    drain();

    // Quarter turn about the negative x axis with only the top group selected.
    s.pivot     = '0;
    s.axis[0]   = 32'hc000_0000;
    s.axis[1]   = 32'h0;
    s.axis[2]   = 32'h0;
    s.sine      = 32'h4000_0000;
    s.cosine    = 32'h0;
    s.group_sel = 32'h8000_0000;
    load_settings(s);
    foreach (corner_atoms[i]) offer_atom(corner_atoms[i]);
    drain();

    // Random phases, mostly real rotations, with some corner and raw settings.
    // Each phase begins from an idle core, so every setting change is clean.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       s = raw_setting();
        1:       s = corner_setting();
        default: s = unit_setting();
      endcase
      load_settings(s);
      case (ph % 3)
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 40;
      endcase
      if (ph == 1 || $urandom_range(0, 4) == 0) begin
        sink_hold_req = 1'b1;
      end
      repeat (ATOMS_PER_PHASE) offer_atom(random_atom(s));
      drain();
    end

    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
